### sv/bjo_pkg.sv
// shared constants and types for the batch job scheduler
package bjo_pkg;

  localparam int MAX_JOBS_DEF   = 16;
  localparam int BURST_BITS_DEF = 16;
  localparam int RESULT_CAP     = 16;

  // ordering modes
  localparam logic [1:0] MODE_ARRIVAL  = 2'd0;
  localparam logic [1:0] MODE_BURST    = 2'd1;
  localparam logic [1:0] MODE_PRIORITY = 2'd2;

  typedef struct packed {
    logic [15:0] burst_time;
    logic [7:0]  job_priority;
    logic        last_job;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  job_index;
    logic [15:0] served_burst;
    logic [7:0]  served_priority;
    logic [19:0] wait_time;
    logic [19:0] turnaround;
    logic [23:0] total_wait;
    logic [23:0] total_turnaround;
    logic        overflow;
    logic        last_result;
  } out_item_t;

  // control broadcast to every cell of the ordering chain
  typedef struct packed {
    logic       insert;
    logic       shift;
    logic [1:0] mode;
  } chain_ctl_t;

endpackage

### sv/bjo_stream_if.sv
// valid/ready stream channel carrying one item per transaction
interface bjo_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/batch_job_order_and_wait_times.sv
// Batch job scheduler top level
//
// jobs (sink): one transaction per job with burst_time, job_priority and
// last_job. Up to MAX_JOBS jobs are kept; later ones are dropped and the
// batch is flagged with overflow. last_job closes the batch.
// order_mode_we/order_mode_wdata: order_mode register, sampled when the batch
// closes (0 arrival order, 1 shortest burst, 2 lowest priority value).
// sched (source): one transaction per job in service order, up to RESULT_CAP
// jobs, with its wait and turnaround time; the final one carries the totals
// and last_result. Timing: jobs load at one per cycle. After the closing job
// the stored jobs are read from the job memory, one per cycle, and inserted
// into a chain of MAX_JOBS cells. Results then stream at one per cycle from
// the chain head unless the receiver stalls, through the pending and output
// registers. jobs.ready is low from the closing job until the last result is
// in the output register.
// A stalled receiver holds the output register and the chain stops shifting.
// Reset clears the job count, the overflow flag, the chain and the mode.
module batch_job_order_and_wait_times
  import bjo_pkg::*;
#(
  parameter int MAX_JOBS   = MAX_JOBS_DEF,
  parameter int BURST_BITS = BURST_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         order_mode_we,
  input  logic [1:0]   order_mode_wdata,
  bjo_stream_if.sink   jobs,
  bjo_stream_if.source sched
);

  localparam int SB = (BURST_BITS < 16) ? BURST_BITS : 16;
  localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int PW = $clog2(MAX_JOBS + 1);
  localparam int EW = 1 + SB + 8 + AW;
  localparam int DW = SB + 8;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t        state;
  logic [1:0]    order_mode;
  logic [1:0]    mode_latched;
  logic [PW-1:0] job_count;
  logic          dropped;
  logic          batch_overflow;
  logic [PW-1:0] rd_ptr;
  logic [DW-1:0] rd_data;
  logic [AW-1:0] rd_idx;
  logic          rd_vld;
  logic [DW-1:0] job_store [MAX_JOBS];
  logic          accept;
  logic          has_room;
  logic          emit_shift;
  logic          emit_done;
  chain_ctl_t    ctl;
  logic [EW-1:0] new_entry;
  logic [EW-1:0] cell_entry [MAX_JOBS];
  logic          cell_go [MAX_JOBS];

  assign jobs.ready = (state == ST_LOAD);
  assign accept     = jobs.valid && jobs.ready;
  assign has_room   = job_count < PW'(MAX_JOBS);

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= MODE_ARRIVAL;
    end else if (order_mode_we) begin
      order_mode <= order_mode_wdata;
    end
  end

  // job memory, written in arrival order
  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      job_store[job_count[AW-1:0]] <= {SB'(jobs.data.burst_time), jobs.data.job_priority};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SORT && rd_ptr < job_count) begin
      rd_data <= job_store[rd_ptr[AW-1:0]];
      rd_idx  <= rd_ptr[AW-1:0];
    end
  end

  // batch control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOAD;
      job_count      <= '0;
      dropped        <= 1'b0;
      batch_overflow <= 1'b0;
      mode_latched   <= MODE_ARRIVAL;
      rd_ptr         <= '0;
      rd_vld         <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (has_room) begin
              job_count <= job_count + PW'(1);
            end
            if (jobs.data.last_job) begin
              batch_overflow <= dropped || !has_room;
              dropped        <= 1'b0;
              mode_latched   <= order_mode;
              rd_ptr         <= '0;
              state          <= ST_SORT;
            end else if (!has_room) begin
              dropped <= 1'b1;
            end
          end
        end
        ST_SORT: begin
          if (rd_ptr < job_count) begin
            rd_ptr <= rd_ptr + PW'(1);
            rd_vld <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
            if (rd_vld) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (emit_done) begin
            job_count <= '0;
            state     <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // ordering chain
  assign ctl.insert = (state == ST_SORT) && rd_vld;
  assign ctl.shift  = emit_shift;
  assign ctl.mode   = mode_latched;
  assign new_entry  = {1'b1, rd_data, rd_idx};

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    logic [EW-1:0] prev_e;
    logic [EW-1:0] next_e;
    logic          prev_g;

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_g = cell_go[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
    end

    bjo_cell #(
      .SB (SB),
      .AW (AW),
      .EW (EW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_go    (prev_g),
      .next_entry (next_e),
      .go         (cell_go[i]),
      .entry      (cell_entry[i])
    );
  end

  // result stream
  bjo_emit #(
    .SB (SB),
    .AW (AW),
    .PW (PW),
    .EW (EW)
  ) u_emit (
    .clk            (clk),
    .rst            (rst),
    .en             (state == ST_EMIT),
    .head           (cell_entry[0]),
    .batch_overflow (batch_overflow),
    .shift          (emit_shift),
    .done           (emit_done),
    .sched          (sched)
  );

endmodule

### sv/bjo_cell.sv
// one cell of the ordering chain: holds a job, inserts in key order, shifts toward the head
module bjo_cell
  import bjo_pkg::*;
#(
  parameter int SB = 16,
  parameter int AW = 4,
  parameter int EW = 1 + SB + 8 + AW
) (
  input  logic          clk,
  input  logic          rst,
  input  chain_ctl_t    ctl,
  input  logic [EW-1:0] new_entry,
  input  logic [EW-1:0] prev_entry,
  input  logic          prev_go,
  input  logic [EW-1:0] next_entry,
  output logic          go,
  output logic [EW-1:0] entry
);

  localparam int KW = (SB > 8) ? SB : 8;

  typedef struct packed {
    logic          vld;
    logic [SB-1:0] burst;
    logic [7:0]    prio;
    logic [AW-1:0] idx;
  } entry_t;

  entry_t cur;
  entry_t nw;
  logic [KW-1:0] key_new;
  logic [KW-1:0] key_cur;

  assign cur = entry_t'(entry);
  assign nw  = entry_t'(new_entry);

  // sort key for the selected mode, zero for arrival order
  always_comb begin
    case (ctl.mode)
      MODE_BURST: begin
        key_new = KW'(nw.burst);
        key_cur = KW'(cur.burst);
      end
      MODE_PRIORITY: begin
        key_new = KW'(nw.prio);
        key_cur = KW'(cur.prio);
      end
      default: begin
        key_new = '0;
        key_cur = '0;
      end
    endcase
  end

  // the new job lands ahead of this cell: equal keys keep the earlier arrival first
  assign go = !cur.vld || (key_new < key_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (ctl.insert) begin
      if (prev_go) begin
        entry <= prev_entry;
      end else if (go) begin
        entry <= new_entry;
      end
    end else if (ctl.shift) begin
      entry <= next_entry;
    end
  end

endmodule

### sv/bjo_emit.sv
// walks the ordered chain, accumulates wait and turnaround, drives the result stream
module bjo_emit
  import bjo_pkg::*;
#(
  parameter int SB = 16,
  parameter int AW = 4,
  parameter int PW = 5,
  parameter int EW = 1 + SB + 8 + AW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [EW-1:0]        head,
  input  logic                 batch_overflow,
  output logic                 shift,
  output logic                 done,
  bjo_stream_if.source         sched
);

  typedef struct packed {
    logic          vld;
    logic [SB-1:0] burst;
    logic [7:0]    prio;
    logic [AW-1:0] idx;
  } entry_t;

  entry_t    hd;
  logic [PW-1:0] pos;
  logic [19:0]   run_wait;
  logic [23:0]   wait_sum;
  logic [23:0]   ta_sum;
  logic [19:0]   w_cur;
  logic [19:0]   t_cur;
  logic          in_cap;
  logic          out_free;
  logic          take;
  out_item_t     pend;
  logic          pend_vld;
  out_item_t     pend_last;
  out_item_t     res;
  logic          res_vld;

  assign hd       = entry_t'(head);
  assign in_cap   = 32'(pos) < RESULT_CAP;
  assign out_free = !res_vld || sched.ready;
  assign w_cur    = run_wait;
  assign t_cur    = run_wait + 20'(hd.burst);

  // jobs beyond the result cap only feed the totals
  assign take  = en && hd.vld && (!in_cap || !pend_vld || out_free);
  assign done  = en && !hd.vld && pend_vld && out_free;
  assign shift = take;

  // running sums and position in service order
  always_ff @(posedge clk) begin
    if (rst || done) begin
      pos      <= '0;
      run_wait <= '0;
      wait_sum <= '0;
      ta_sum   <= '0;
    end else if (take) begin
      pos      <= pos + PW'(1);
      run_wait <= t_cur;
      wait_sum <= wait_sum + 24'(w_cur);
      ta_sum   <= ta_sum + 24'(t_cur);
    end
  end

  // pending result waits until it is known whether it closes the schedule
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (done) begin
      pend_vld <= 1'b0;
    end else if (take && in_cap) begin
      pend_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_cap) begin
      pend.job_index        <= 4'(hd.idx);
      pend.served_burst     <= 16'(hd.burst);
      pend.served_priority  <= hd.prio;
      pend.wait_time        <= w_cur;
      pend.turnaround       <= t_cur;
      pend.total_wait       <= '0;
      pend.total_turnaround <= '0;
      pend.overflow         <= batch_overflow;
      pend.last_result      <= 1'b0;
    end
  end

  // closing result carries the batch totals
  always_comb begin
    pend_last                  = pend;
    pend_last.total_wait       = wait_sum;
    pend_last.total_turnaround = ta_sum;
    pend_last.last_result      = 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (done || (take && in_cap && pend_vld)) begin
      res_vld <= 1'b1;
    end else if (sched.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res <= pend_last;
    end else if (take && in_cap && pend_vld) begin
      res <= pend;
    end
  end

  assign sched.valid = res_vld;
  assign sched.data  = res;

endmodule
